FILE: rtl/sme_pkg.sv
// ----------------------------------------------------------------------------
// Stack machine executor package
// Shared widths, action codes, decoded operations, status codes and the
// structs passed between the front end, the queue and the execution back end.
// ----------------------------------------------------------------------------
package sme_pkg;

  localparam int unsigned ACTION_W    = 4;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned IN_DATA_W   = 40;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;
  localparam int unsigned DIV_CNT_W   = 6;

  localparam logic [COUNT_W-1:0]   LIMIT_RESET = 16'd10000;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS   = 6'd32;

  // Action codes as they arrive on the input stream
  localparam logic [ACTION_W-1:0] ACT_NOP   = 4'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH  = 4'd1;
  localparam logic [ACTION_W-1:0] ACT_POP   = 4'd2;
  localparam logic [ACTION_W-1:0] ACT_ADD   = 4'd3;
  localparam logic [ACTION_W-1:0] ACT_SUB   = 4'd4;
  localparam logic [ACTION_W-1:0] ACT_MUL   = 4'd5;
  localparam logic [ACTION_W-1:0] ACT_DIV   = 4'd6;
  localparam logic [ACTION_W-1:0] ACT_PRINT = 4'd7;
  localparam logic [ACTION_W-1:0] ACT_HALT  = 4'd8;

  typedef enum logic [3:0] {
    OP_NOP, OP_PUSH, OP_POP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_PRINT, OP_HALT, OP_BAD
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_RUNNING = 2'd0,
    ST_HALTED  = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_LIMIT   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE, BK_PRINT, BK_OPB, BK_OPA, BK_EXEC, BK_DIVS, BK_DIVW, BK_DONE
  } back_state_e;

  typedef struct packed {
    op_e               op;
    logic [WORD_W-1:0] imm;
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic              print_valid;
    logic [WORD_W-1:0] printed_value;
    status_e           status;
  } res_t;

endpackage

FILE: rtl/sme_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sme_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/sme_front.sv
// ----------------------------------------------------------------------------
// Stack machine front end
// Accepts input transactions, decodes the action code into an operation
// class and holds the decoded command in a register stage.
// ----------------------------------------------------------------------------
module sme_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sme_pkg::IN_DATA_W-1:0] in_data_i,
  output logic                          cmd_valid_o,
  input  logic                          cmd_ready_i,
  output sme_pkg::cmd_t                 cmd_o
);

  logic          valid_q, valid_d;
  sme_pkg::cmd_t cmd_q, cmd_d;
  sme_pkg::op_e  op_dec;
  logic          take;

  always_comb begin
    case (in_data_i[sme_pkg::ACTION_W-1:0])
      sme_pkg::ACT_NOP:   op_dec = sme_pkg::OP_NOP;
      sme_pkg::ACT_PUSH:  op_dec = sme_pkg::OP_PUSH;
      sme_pkg::ACT_POP:   op_dec = sme_pkg::OP_POP;
      sme_pkg::ACT_ADD:   op_dec = sme_pkg::OP_ADD;
      sme_pkg::ACT_SUB:   op_dec = sme_pkg::OP_SUB;
      sme_pkg::ACT_MUL:   op_dec = sme_pkg::OP_MUL;
      sme_pkg::ACT_DIV:   op_dec = sme_pkg::OP_DIV;
      sme_pkg::ACT_PRINT: op_dec = sme_pkg::OP_PRINT;
      sme_pkg::ACT_HALT:  op_dec = sme_pkg::OP_HALT;
      default:            op_dec = sme_pkg::OP_BAD;
    endcase
  end

  assign in_ready_o = !valid_q || cmd_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (take) begin
      valid_d   = 1'b1;
      cmd_d.op  = op_dec;
      cmd_d.imm = in_data_i[sme_pkg::ACTION_W +: sme_pkg::WORD_W];
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

FILE: rtl/sme_queue.sv
// ----------------------------------------------------------------------------
// Stack machine command queue
// Short FIFO of decoded commands between front end and back end.
// ----------------------------------------------------------------------------
module sme_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sme_pkg::cmd_t in_cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sme_pkg::cmd_t out_cmd_o
);

  sme_pkg::cmd_t               entries_q [sme_pkg::QUEUE_DEPTH];
  logic [sme_pkg::QPTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [sme_pkg::QCNT_W-1:0]  count_q, count_d;
  logic                        push, pop;

  assign in_ready_o  = count_q < sme_pkg::QCNT_W'(sme_pkg::QUEUE_DEPTH);
  assign out_valid_o = count_q != '0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_ready_i && out_valid_o;
  assign out_cmd_o   = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= in_cmd_i;
    end
  end

endmodule

FILE: rtl/sme_div.sv
// ----------------------------------------------------------------------------
// Stack machine divider
// Signed restoring division, one quotient bit per cycle, truncating toward
// zero. Division by zero yields zero.
// ----------------------------------------------------------------------------
module sme_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sme_pkg::div_req_t req_i,
  output sme_pkg::div_rsp_t rsp_o
);

  localparam int unsigned W = sme_pkg::WORD_W;

  logic                          busy_q, busy_d, done_q, done_d;
  logic [sme_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [W-1:0]                  quo_q, quo_d, rem_q, rem_d, dvs_q, dvs_d, res_q, res_d;
  logic                          neg_q, neg_d, zero_q, zero_d;
  logic [W:0]                    shifted, trial;
  logic                          qbit;

  assign shifted = {rem_q, quo_q[W-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign qbit    = !trial[W];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    res_d  = res_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend[W-1] ? (W'(0) - req_i.dividend) : req_i.dividend;
      dvs_d  = req_i.divisor[W-1] ? (W'(0) - req_i.divisor) : req_i.divisor;
      neg_d  = req_i.dividend[W-1] ^ req_i.divisor[W-1];
      zero_d = req_i.divisor == '0;
    end else if (busy_q) begin
      if (cnt_q == sme_pkg::DIV_STEPS) begin
        // Apply sign and the divide-by-zero rule
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = zero_q ? '0 : (neg_q ? (W'(0) - quo_q) : quo_q);
      end else begin
        rem_d = qbit ? trial[W-1:0] : shifted[W-1:0];
        quo_d = {quo_q[W-2:0], qbit};
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    res_q  <= res_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = res_q;

endmodule

FILE: rtl/sme_back.sv
// ----------------------------------------------------------------------------
// Stack machine back end
// Executes decoded commands on the operand stack RAM, tracks stack pointer,
// run status and executed count, and holds the result in an output register.
// ----------------------------------------------------------------------------
module sme_back #(
  parameter int unsigned STACK_DEPTH = 256,
  parameter int unsigned SP_W        = $clog2(STACK_DEPTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [sme_pkg::COUNT_W-1:0] limit_i,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  sme_pkg::cmd_t               cmd_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output sme_pkg::res_t               res_o,
  output logic [SP_W-1:0]             res_depth_o,
  output sme_pkg::status_e            run_status_o
);

  localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
  localparam int unsigned W      = sme_pkg::WORD_W;

  sme_pkg::back_state_e        state_q, state_d;
  sme_pkg::status_e            status_q, status_d, status_fin;
  logic [SP_W-1:0]             sp_q, sp_d, sp_m1, sp_m2;
  logic [sme_pkg::COUNT_W-1:0] cnt_q, cnt_d, cnt_inc;
  sme_pkg::op_e                op_q, op_d;
  logic [W-1:0]                imm_q, imm_d, a_q, a_d, b_q, b_d, pval_q, pval_d;
  logic                        pvalid_q, pvalid_d, exec_q, exec_d;
  logic                        out_valid_q, out_valid_d;
  sme_pkg::res_t               out_q, out_d;
  logic [SP_W-1:0]             out_depth_q, out_depth_d;
  logic                        sp_ge1, sp_ge2, has_room;
  logic                        ram_we;
  logic [ADDR_W-1:0]           ram_waddr, ram_raddr;
  logic [W-1:0]                ram_wdata, ram_rdata, alu_res;
  logic [2*W-1:0]              prod;
  sme_pkg::div_req_t           div_req;
  sme_pkg::div_rsp_t           div_rsp;

  sme_ram #(
    .WIDTH (W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sme_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign sp_m1    = sp_q - SP_W'(1);
  assign sp_m2    = sp_q - SP_W'(2);
  assign sp_ge1   = sp_q != '0;
  assign sp_ge2   = sp_q > SP_W'(1);
  assign has_room = sp_q < SP_W'(STACK_DEPTH);
  assign prod     = a_q * b_q;
  assign cnt_inc  = (cnt_q != '1) ? cnt_q + 1'b1 : cnt_q;

  always_comb begin
    case (op_q)
      sme_pkg::OP_ADD: alu_res = a_q + b_q;
      sme_pkg::OP_SUB: alu_res = a_q - b_q;
      default:         alu_res = prod[W-1:0];
    endcase
  end

  // Limit check: only an executed item that leaves the machine running
  assign status_fin = (exec_q && status_q == sme_pkg::ST_RUNNING && cnt_inc >= limit_i)
                      ? sme_pkg::ST_LIMIT : status_q;

  always_comb begin
    state_d          = state_q;
    status_d         = status_q;
    sp_d             = sp_q;
    cnt_d            = cnt_q;
    op_d             = op_q;
    imm_d            = imm_q;
    a_d              = a_q;
    b_d              = b_q;
    pval_d           = pval_q;
    pvalid_d         = pvalid_q;
    exec_d           = exec_q;
    out_valid_d      = out_valid_q && !res_ready_i;
    out_d            = out_q;
    out_depth_d      = out_depth_q;
    cmd_ready_o      = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = sp_q[ADDR_W-1:0];
    ram_wdata        = imm_q;
    ram_raddr        = sp_m1[ADDR_W-1:0];
    div_req.start    = 1'b0;
    div_req.dividend = a_q;
    div_req.divisor  = b_q;
    case (state_q)
      sme_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_ready_o = 1'b1;
          op_d        = cmd_i.op;
          imm_d       = cmd_i.imm;
          pvalid_d    = 1'b0;
          pval_d      = '0;
          exec_d      = status_q == sme_pkg::ST_RUNNING;
          state_d     = sme_pkg::BK_DONE;
          if (status_q == sme_pkg::ST_RUNNING) begin
            case (cmd_i.op)
              sme_pkg::OP_NOP:  state_d = sme_pkg::BK_DONE;
              sme_pkg::OP_HALT: status_d = sme_pkg::ST_HALTED;
              sme_pkg::OP_BAD:  status_d = sme_pkg::ST_UNKNOWN;
              sme_pkg::OP_PUSH: begin
                // Drop the value on a full stack
                if (has_room) begin
                  ram_we    = 1'b1;
                  ram_wdata = cmd_i.imm;
                  sp_d      = sp_q + SP_W'(1);
                end
              end
              sme_pkg::OP_POP: begin
                if (sp_ge1) begin
                  sp_d = sp_m1;
                end
              end
              sme_pkg::OP_PRINT: state_d = sme_pkg::BK_PRINT;
              default:           state_d = sme_pkg::BK_OPB;
            endcase
          end
        end
      end
      sme_pkg::BK_PRINT: begin
        pvalid_d = 1'b1;
        pval_d   = sp_ge1 ? ram_rdata : '0;
        if (sp_ge1) begin
          sp_d = sp_m1;
        end
        state_d = sme_pkg::BK_DONE;
      end
      sme_pkg::BK_OPB: begin
        b_d       = sp_ge1 ? ram_rdata : '0;
        ram_raddr = sp_m2[ADDR_W-1:0];
        state_d   = sme_pkg::BK_OPA;
      end
      sme_pkg::BK_OPA: begin
        a_d     = sp_ge2 ? ram_rdata : '0;
        sp_d    = sp_ge2 ? sp_m2 : '0;
        state_d = (op_q == sme_pkg::OP_DIV) ? sme_pkg::BK_DIVS : sme_pkg::BK_EXEC;
      end
      sme_pkg::BK_EXEC: begin
        ram_we    = 1'b1;
        ram_wdata = alu_res;
        sp_d      = sp_q + SP_W'(1);
        state_d   = sme_pkg::BK_DONE;
      end
      sme_pkg::BK_DIVS: begin
        div_req.start = 1'b1;
        state_d       = sme_pkg::BK_DIVW;
      end
      sme_pkg::BK_DIVW: begin
        if (div_rsp.done) begin
          ram_we    = 1'b1;
          ram_wdata = div_rsp.quotient;
          sp_d      = sp_q + SP_W'(1);
          state_d   = sme_pkg::BK_DONE;
        end
      end
      sme_pkg::BK_DONE: begin
        if (!out_valid_q || res_ready_i) begin
          out_valid_d         = 1'b1;
          out_d.print_valid   = pvalid_q;
          out_d.printed_value = pval_q;
          out_d.status        = status_fin;
          out_depth_d         = sp_q;
          status_d            = status_fin;
          if (exec_q) begin
            cnt_d = cnt_inc;
          end
          state_d = sme_pkg::BK_IDLE;
        end
      end
      default: state_d = sme_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sme_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q    <= sme_pkg::ST_RUNNING;
      sp_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      status_q    <= status_d;
      sp_q        <= sp_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    imm_q       <= imm_d;
    a_q         <= a_d;
    b_q         <= b_d;
    pval_q      <= pval_d;
    pvalid_q    <= pvalid_d;
    exec_q      <= exec_d;
    out_q       <= out_d;
    out_depth_q <= out_depth_d;
  end

  assign res_valid_o  = out_valid_q;
  assign res_o        = out_q;
  assign res_depth_o  = out_depth_q;
  assign run_status_o = status_q;

endmodule

FILE: rtl/stack_machine_executor_unit.sv
// ----------------------------------------------------------------------------
// Stack machine executor unit
// Executes decoded stack machine instructions on a 32-bit operand stack and
// returns one result transaction per instruction.
// ----------------------------------------------------------------------------
//
// Channel    Dir  Handshake               Payload
// s_axis     in   tvalid/tready           tdata: action[3:0], immediate[35:4]
// m_axis     out  tvalid/tready           tuser: print_valid
//                                         tdata: printed_value[31:0],
//                                                status[33:32], stack_depth above
// cfg        in   cfg_we_i (no wait)      cfg_wdata_i: insn_limit
//
// Back end path while running, IDLE to DONE: direct for nop, push, pop, halt and
// unknown actions; via PRINT for print; via OPB, OPA, EXEC for add, sub and mul
// (two stack RAM reads through the registered read port, then one write); for
// div via OPB, OPA, DIVS, DIVW; divider: load, one quotient bit a cycle, sign fix.
// Reset clears the stack pointer, status, executed count, queue and the front
// and output valid flags; insn_limit returns to 10000. Stack RAM is not cleared.
// A stalled result holds in the output register while the back end takes the
// next command; the front register and a two-entry queue absorb input stalls.
// ----------------------------------------------------------------------------
module stack_machine_executor_unit #(
  parameter  int unsigned STACK_DEPTH = 256,
  localparam int unsigned DEPTH_W     = $clog2(STACK_DEPTH + 1),
  localparam int unsigned OUT_DATA_W  = ((sme_pkg::WORD_W + sme_pkg::STATUS_W + DEPTH_W + 7)
                                         / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata: action[3:0], immediate[35:4], zero pad
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [sme_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // tdata: printed_value, status, stack_depth, zero pad
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [OUT_DATA_W-1:0]         m_axis_tdata,
  // tuser: print_valid
  output logic [0:0]                    m_axis_tuser,
  input  logic                          cfg_we_i,
  input  logic [sme_pkg::COUNT_W-1:0]   cfg_wdata_i
);

  logic [sme_pkg::COUNT_W-1:0] limit_q;
  logic                        fr_valid, fr_ready;
  sme_pkg::cmd_t               fr_cmd;
  logic                        cmd_valid, cmd_ready;
  sme_pkg::cmd_t               cmd;
  sme_pkg::res_t               res;
  logic [DEPTH_W-1:0]          res_depth;
  sme_pkg::status_e            run_status;

  // Instruction limit register; the user must write it only while the unit is idle, as the block leaves this unchecked
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= sme_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Front end: accept and decode the incoming transaction
  sme_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready),
    .cmd_o       (fr_cmd)
  );

  // Decoupling queue between decode and execution
  sme_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_cmd_i    (fr_cmd),
    .out_valid_o (cmd_valid),
    .out_ready_i (cmd_ready),
    .out_cmd_o   (cmd)
  );

  // Back end: stack RAM, divider and result register
  sme_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .SP_W        (DEPTH_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .limit_i      (limit_q),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res),
    .res_depth_o  (res_depth),
    .run_status_o (run_status)
  );

  // Pack the result fields, lowest first; pad the top with zeros
  assign m_axis_tdata = OUT_DATA_W'({res_depth, res.status, res.printed_value});
  assign m_axis_tuser = res.print_valid;

  // Reported depth never exceeds the stack size
  a_depth_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res_depth <= DEPTH_W'(STACK_DEPTH)))
    else $error("stack depth beyond stack size");

  // Once stopped, the machine stays in the same stop status
  a_stop_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_status != sme_pkg::ST_RUNNING) |=> (run_status == $past(run_status)))
    else $error("stop status changed");

  // The back end only takes a command that the queue offers
  a_pop_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_ready |-> cmd_valid)
    else $error("command taken from empty queue");

  // A printed result carries a status set by an executed item, never halted
  // before it: print_valid implies status is running or limit
  a_print_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.print_valid) |->
      (res.status == sme_pkg::ST_RUNNING || res.status == sme_pkg::ST_LIMIT))
    else $error("print result with halt or fault status");

endmodule
